[hw/rtl/clde_pkg.sv]
// clde_pkg: shared types, key codes, reset values and the segment decoder
// for the clock digit editor display unit; no dependencies
package clde_pkg;

    localparam int NUM_DIGITS           = 6;
    localparam int FRAMES_PER_PHASE_DEF = 10;
    localparam int CURSOR_W             = 3;

    // request operations
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // active-low key codes
    localparam logic [7:0] KEY_RIGHT = 8'hfe;
    localparam logic [7:0] KEY_EDIT  = 8'hfd;
    localparam logic [7:0] KEY_UP    = 8'hfb;
    localparam logic [7:0] KEY_DOWN  = 8'hf7;

    // digit positions
    localparam logic [CURSOR_W-1:0] POS_HOUR_TENS   = 3'd0;
    localparam logic [CURSOR_W-1:0] POS_HOUR_ONES   = 3'd1;
    localparam logic [CURSOR_W-1:0] POS_MINUTE_TENS = 3'd2;
    localparam logic [CURSOR_W-1:0] POS_MINUTE_ONES = 3'd3;
    localparam logic [CURSOR_W-1:0] POS_SECOND_TENS = 3'd4;
    localparam logic [CURSOR_W-1:0] POS_SECOND_ONES = 3'd5;
    localparam logic [CURSOR_W-1:0] POS_LAST        = CURSOR_W'(NUM_DIGITS - 1);

    localparam logic [7:0] SEL_OFF   = 8'hff;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_DP    = 8'h80;

    typedef struct packed {
        logic       operation;
        logic [7:0] key_code;
    } t_in_req;

    typedef struct packed {
        logic [7:0]          digit_select;
        logic [7:0]          segments;
        logic [1:0]          hour_tens;
        logic [3:0]          hour_ones;
        logic [2:0]          minute_tens;
        logic [3:0]          minute_ones;
        logic [2:0]          second_tens;
        logic [3:0]          second_ones;
        logic [CURSOR_W-1:0] cursor_position;
        logic                edit_mode;
    } t_out_rsp;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
    } t_time;

    typedef struct packed {
        t_time               digits;
        logic [CURSOR_W-1:0] cursor;
        logic                edit;
    } t_clock_state;

    localparam t_time TIME_RESET = '{
        hour_tens:   2'd2,
        hour_ones:   4'd3,
        minute_tens: 3'd5,
        minute_ones: 4'd9,
        second_tens: 3'd5,
        second_ones: 4'd0
    };

    function automatic logic [7:0] seg_pattern(input logic [3:0] value);
        logic [7:0] pat;
        case (value)
            4'd0: pat = 8'h3f;
            4'd1: pat = 8'h06;
            4'd2: pat = 8'h5b;
            4'd3: pat = 8'h4f;
            4'd4: pat = 8'h66;
            4'd5: pat = 8'h6d;
            4'd6: pat = 8'h7d;
            4'd7: pat = 8'h07;
            4'd8: pat = 8'h7f;
            4'd9: pat = 8'h6f;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

[hw/rtl/clock_digit_editor_display_unit.sv]
// clock_digit_editor_display_unit: top level with request and response registers
// depends on clde_pkg, clde_key_ctrl, clde_scan_ctrl
//
//  channel   valid         stall         payload
//  request   i_in_valid    o_in_stall    i_in_req  (clde_pkg::t_in_req)
//  response  o_out_valid   i_out_stall   o_out_rsp (clde_pkg::t_out_rsp)
//
// one request per cycle while the response is not stalled; a taken request passes the
// request register, then one pass of key/scan logic into the response register
// reset restores 23:59:50, cursor 0, edit off, scan position and frame count 0
// a stalled response holds the pipeline; the request register still takes one more
// request while the response waits
module clock_digit_editor_display_unit #(
    parameter int FRAMES_PER_PHASE = clde_pkg::FRAMES_PER_PHASE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  clde_pkg::t_in_req  i_in_req,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output clde_pkg::t_out_rsp o_out_rsp,
    input  logic               i_out_stall
);

    logic                   r_in_valid;
    clde_pkg::t_in_req      r_in_req;
    logic                   r_out_valid;
    clde_pkg::t_out_rsp     r_out_rsp;
    clde_pkg::t_out_rsp     n_out_rsp;
    logic                   advance;
    logic                   fire;
    clde_pkg::t_clock_state cur_state;
    clde_pkg::t_clock_state nxt_state;
    logic [7:0]             scan_sel;
    logic [7:0]             scan_seg;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    clde_key_ctrl u_key_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_req        (r_in_req),
        .o_state      (cur_state),
        .o_next_state (nxt_state)
    );

    clde_scan_ctrl #(
        .FRAMES_PER_PHASE (FRAMES_PER_PHASE)
    ) u_scan_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_req          (r_in_req),
        .i_state        (cur_state),
        .o_digit_select (scan_sel),
        .o_segments     (scan_seg)
    );

    always_comb begin
        n_out_rsp.hour_tens       = nxt_state.digits.hour_tens;
        n_out_rsp.hour_ones       = nxt_state.digits.hour_ones;
        n_out_rsp.minute_tens     = nxt_state.digits.minute_tens;
        n_out_rsp.minute_ones     = nxt_state.digits.minute_ones;
        n_out_rsp.second_tens     = nxt_state.digits.second_tens;
        n_out_rsp.second_ones     = nxt_state.digits.second_ones;
        n_out_rsp.cursor_position = nxt_state.cursor;
        n_out_rsp.edit_mode       = nxt_state.edit;
        if (r_in_req.operation == clde_pkg::OP_SCAN) begin
            n_out_rsp.digit_select = scan_sel;
            n_out_rsp.segments     = scan_seg;
        end else begin
            n_out_rsp.digit_select = clde_pkg::SEL_OFF;
            n_out_rsp.segments     = clde_pkg::SEG_BLANK;
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_req <= i_in_req;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

[hw/rtl/clde_key_ctrl.sv]
// clde_key_ctrl: time digits, cursor and edit flag, updated by key requests
// depends on clde_pkg
module clde_key_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  clde_pkg::t_in_req     i_req,
    output clde_pkg::t_clock_state o_state,
    output clde_pkg::t_clock_state o_next_state
);

    clde_pkg::t_clock_state r_state;
    clde_pkg::t_clock_state n_state;

    function automatic clde_pkg::t_time adv_hour(input clde_pkg::t_time t);
        clde_pkg::t_time v;
        v = t;
        if (t.hour_tens <= 2'd1) begin
            if (t.hour_ones >= 4'd9) begin
                v.hour_ones = 4'd0;
                v.hour_tens = t.hour_tens + 2'd1;
            end else begin
                v.hour_ones = t.hour_ones + 4'd1;
            end
        end else if (t.hour_tens == 2'd2) begin
            if (t.hour_ones >= 4'd3) begin
                v.hour_ones = 4'd0;
                v.hour_tens = 2'd0;
            end else begin
                v.hour_ones = t.hour_ones + 4'd1;
            end
        end
        return v;
    endfunction

    function automatic clde_pkg::t_time adv_minute(input clde_pkg::t_time t);
        clde_pkg::t_time v;
        v = t;
        if (t.minute_ones >= 4'd9) begin
            v.minute_ones = 4'd0;
            if (t.minute_tens >= 3'd5) begin
                v.minute_tens = 3'd0;
                v = adv_hour(v);
            end else begin
                v.minute_tens = t.minute_tens + 3'd1;
            end
        end else begin
            v.minute_ones = t.minute_ones + 4'd1;
        end
        return v;
    endfunction

    function automatic clde_pkg::t_time inc_digit(
        input clde_pkg::t_time                     t,
        input logic [clde_pkg::CURSOR_W-1:0]       pos
    );
        clde_pkg::t_time v;
        v = t;
        case (pos)
            clde_pkg::POS_HOUR_TENS: begin
                v.hour_tens = (t.hour_tens >= 2'd2) ? 2'd0 : t.hour_tens + 2'd1;
            end
            clde_pkg::POS_HOUR_ONES: begin
                v = adv_hour(t);
            end
            clde_pkg::POS_MINUTE_TENS: begin
                v.minute_tens = (t.minute_tens >= 3'd5) ? 3'd0 : t.minute_tens + 3'd1;
            end
            clde_pkg::POS_MINUTE_ONES: begin
                v = adv_minute(t);
            end
            clde_pkg::POS_SECOND_TENS: begin
                v.second_tens = (t.second_tens >= 3'd5) ? 3'd0 : t.second_tens + 3'd1;
            end
            clde_pkg::POS_SECOND_ONES: begin
                if (t.second_ones >= 4'd9) begin
                    v.second_ones = 4'd0;
                    if (t.second_tens >= 3'd5) begin
                        v.second_tens = 3'd0;
                        v = adv_minute(v);
                    end else begin
                        v.second_tens = t.second_tens + 3'd1;
                    end
                end else begin
                    v.second_ones = t.second_ones + 4'd1;
                end
            end
            default: begin
                v = t;
            end
        endcase
        return v;
    endfunction

    function automatic clde_pkg::t_time dec_digit(
        input clde_pkg::t_time                     t,
        input logic [clde_pkg::CURSOR_W-1:0]       pos
    );
        clde_pkg::t_time v;
        v = t;
        case (pos)
            clde_pkg::POS_HOUR_TENS: begin
                if (t.hour_tens != 2'd0) v.hour_tens = t.hour_tens - 2'd1;
            end
            clde_pkg::POS_HOUR_ONES: begin
                if (t.hour_ones != 4'd0) v.hour_ones = t.hour_ones - 4'd1;
            end
            clde_pkg::POS_MINUTE_TENS: begin
                if (t.minute_tens != 3'd0) v.minute_tens = t.minute_tens - 3'd1;
            end
            clde_pkg::POS_MINUTE_ONES: begin
                if (t.minute_ones != 4'd0) v.minute_ones = t.minute_ones - 4'd1;
            end
            clde_pkg::POS_SECOND_TENS: begin
                if (t.second_tens != 3'd0) v.second_tens = t.second_tens - 3'd1;
            end
            clde_pkg::POS_SECOND_ONES: begin
                if (t.second_ones != 4'd0) v.second_ones = t.second_ones - 4'd1;
            end
            default: begin
                v = t;
            end
        endcase
        return v;
    endfunction

    always_comb begin
        n_state = r_state;
        if (i_fire && (i_req.operation == clde_pkg::OP_KEY)) begin
            if (i_req.key_code == clde_pkg::KEY_EDIT) begin
                n_state.edit = ~r_state.edit;
            end else if (r_state.edit) begin
                case (i_req.key_code)
                    clde_pkg::KEY_RIGHT: begin
                        n_state.cursor = (r_state.cursor >= clde_pkg::POS_LAST)
                                       ? '0 : r_state.cursor + 3'd1;
                    end
                    clde_pkg::KEY_UP: begin
                        n_state.digits = inc_digit(r_state.digits, r_state.cursor);
                    end
                    clde_pkg::KEY_DOWN: begin
                        n_state.digits = dec_digit(r_state.digits, r_state.cursor);
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.digits <= clde_pkg::TIME_RESET;
            r_state.cursor <= '0;
            r_state.edit   <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state      = r_state;
    assign o_next_state = n_state;

endmodule

[hw/rtl/clde_scan_ctrl.sv]
// clde_scan_ctrl: scan position, blink frame counter and digit/segment drive
// depends on clde_pkg
module clde_scan_ctrl #(
    parameter int FRAMES_PER_PHASE = clde_pkg::FRAMES_PER_PHASE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  clde_pkg::t_in_req      i_req,
    input  clde_pkg::t_clock_state i_state,
    output logic [7:0]             o_digit_select,
    output logic [7:0]             o_segments
);

    localparam int CNT_W = $clog2(2 * FRAMES_PER_PHASE);
    localparam logic [CNT_W-1:0] CNT_PHASE = CNT_W'(FRAMES_PER_PHASE);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(2 * FRAMES_PER_PHASE - 1);

    logic [CNT_W-1:0]              r_frame_cnt;
    logic [CNT_W-1:0]              n_frame_cnt;
    logic [clde_pkg::CURSOR_W-1:0] r_scan_pos;
    logic [clde_pkg::CURSOR_W-1:0] n_scan_pos;
    logic                          blink;
    logic                          blank;
    logic [3:0]                    digit_val;
    logic [7:0]                    pat;

    assign blink = (r_frame_cnt >= CNT_PHASE);
    assign blank = i_state.edit && blink && (r_scan_pos == i_state.cursor);

    always_comb begin
        case (r_scan_pos)
            clde_pkg::POS_HOUR_TENS:   digit_val = {2'b00, i_state.digits.hour_tens};
            clde_pkg::POS_HOUR_ONES:   digit_val = i_state.digits.hour_ones;
            clde_pkg::POS_MINUTE_TENS: digit_val = {1'b0, i_state.digits.minute_tens};
            clde_pkg::POS_MINUTE_ONES: digit_val = i_state.digits.minute_ones;
            clde_pkg::POS_SECOND_TENS: digit_val = {1'b0, i_state.digits.second_tens};
            clde_pkg::POS_SECOND_ONES: digit_val = i_state.digits.second_ones;
            default:                   digit_val = 4'd0;
        endcase
    end

    always_comb begin
        pat = clde_pkg::seg_pattern(digit_val);
        if ((r_scan_pos == clde_pkg::POS_HOUR_ONES)
                || (r_scan_pos == clde_pkg::POS_MINUTE_ONES)) begin
            pat = pat | clde_pkg::SEG_DP;
        end
    end

    assign o_digit_select = blank ? clde_pkg::SEL_OFF : ~(8'd1 << r_scan_pos);
    assign o_segments     = blank ? clde_pkg::SEG_BLANK : pat;

    always_comb begin
        n_scan_pos  = r_scan_pos;
        n_frame_cnt = r_frame_cnt;
        if (i_fire && (i_req.operation == clde_pkg::OP_SCAN)) begin
            if (r_scan_pos >= clde_pkg::POS_LAST) begin
                n_scan_pos  = '0;
                n_frame_cnt = (r_frame_cnt >= CNT_LAST) ? '0 : r_frame_cnt + CNT_W'(1);
            end else begin
                n_scan_pos = r_scan_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos  <= '0;
            r_frame_cnt <= '0;
        end else begin
            r_scan_pos  <= n_scan_pos;
            r_frame_cnt <= n_frame_cnt;
        end
    end

endmodule

[dv/clock_digit_editor_display_unit_tb.sv]
// clock_digit_editor_display_unit_tb: self-checking bench for the clock digit editor,
// key and scan requests against an in-bench clock model with random idle and stall
// depends on clde_pkg and clock_digit_editor_display_unit
module clock_digit_editor_display_unit_tb;

    localparam int FRAMES_PER_PHASE = clde_pkg::FRAMES_PER_PHASE_DEF;
    localparam int RANDOM_ITEMS     = 1220;
    localparam int CALM_TAIL        = 150;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int DRAIN_CYCLES     = 10;

    localparam logic [7:0] SEG_FONT [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    clde_pkg::t_in_req  i_in_req    = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    clde_pkg::t_out_rsp o_out_rsp;
    logic               i_out_stall = 1'b0;

    clde_pkg::t_in_req  key_scan_queue [$];
    clde_pkg::t_out_rsp expected_readouts [$];

    logic [3:0] clock_digits [clde_pkg::NUM_DIGITS];
    logic [2:0] cursor_pos;
    logic       editing;
    logic [6:0] frame_cnt;
    logic [2:0] scan_pos;

    int send_gap    = 0;
    int hold_left   = 0;
    int errors      = 0;
    int cycle_count = 0;

    clock_digit_editor_display_unit #(
        .FRAMES_PER_PHASE(FRAMES_PER_PHASE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void advance_hour();
        if (clock_digits[clde_pkg::POS_HOUR_TENS] == 4'd2) begin
            if (clock_digits[clde_pkg::POS_HOUR_ONES] >= 4'd3) begin
                clock_digits[clde_pkg::POS_HOUR_ONES] = 4'd0;
                clock_digits[clde_pkg::POS_HOUR_TENS] = 4'd0;
            end else begin
                clock_digits[clde_pkg::POS_HOUR_ONES] =
                    clock_digits[clde_pkg::POS_HOUR_ONES] + 4'd1;
            end
        end else if (clock_digits[clde_pkg::POS_HOUR_ONES] >= 4'd9) begin
            clock_digits[clde_pkg::POS_HOUR_ONES] = 4'd0;
            clock_digits[clde_pkg::POS_HOUR_TENS] =
                clock_digits[clde_pkg::POS_HOUR_TENS] + 4'd1;
        end else begin
            clock_digits[clde_pkg::POS_HOUR_ONES] =
                clock_digits[clde_pkg::POS_HOUR_ONES] + 4'd1;
        end
    endfunction

    function automatic void advance_minute();
        if (clock_digits[clde_pkg::POS_MINUTE_ONES] >= 4'd9) begin
            clock_digits[clde_pkg::POS_MINUTE_ONES] = 4'd0;
            if (clock_digits[clde_pkg::POS_MINUTE_TENS] >= 4'd5) begin
                clock_digits[clde_pkg::POS_MINUTE_TENS] = 4'd0;
                advance_hour();
            end else begin
                clock_digits[clde_pkg::POS_MINUTE_TENS] =
                    clock_digits[clde_pkg::POS_MINUTE_TENS] + 4'd1;
            end
        end else begin
            clock_digits[clde_pkg::POS_MINUTE_ONES] =
                clock_digits[clde_pkg::POS_MINUTE_ONES] + 4'd1;
        end
    endfunction

    function automatic clde_pkg::t_out_rsp clock_step(input clde_pkg::t_in_req req);
        clde_pkg::t_out_rsp rsp;
        logic [2:0]         pos;
        rsp.digit_select = clde_pkg::SEL_OFF;
        rsp.segments     = clde_pkg::SEG_BLANK;
        if (req.operation == clde_pkg::OP_KEY) begin
            if (req.key_code == clde_pkg::KEY_EDIT) begin
                editing = !editing;
            end else if (editing) begin
                case (req.key_code)
                    clde_pkg::KEY_RIGHT: begin
                        cursor_pos = (cursor_pos == clde_pkg::POS_LAST)
                                   ? clde_pkg::POS_HOUR_TENS : cursor_pos + 3'd1;
                    end
                    clde_pkg::KEY_UP: begin
                        case (cursor_pos)
                            clde_pkg::POS_HOUR_TENS: begin
                                clock_digits[clde_pkg::POS_HOUR_TENS] =
                                    (clock_digits[clde_pkg::POS_HOUR_TENS] >= 4'd2) ? 4'd0
                                    : clock_digits[clde_pkg::POS_HOUR_TENS] + 4'd1;
                            end
                            clde_pkg::POS_HOUR_ONES: advance_hour();
                            clde_pkg::POS_MINUTE_TENS: begin
                                clock_digits[clde_pkg::POS_MINUTE_TENS] =
                                    (clock_digits[clde_pkg::POS_MINUTE_TENS] >= 4'd5) ? 4'd0
                                    : clock_digits[clde_pkg::POS_MINUTE_TENS] + 4'd1;
                            end
                            clde_pkg::POS_MINUTE_ONES: advance_minute();
                            clde_pkg::POS_SECOND_TENS: begin
                                clock_digits[clde_pkg::POS_SECOND_TENS] =
                                    (clock_digits[clde_pkg::POS_SECOND_TENS] >= 4'd5) ? 4'd0
                                    : clock_digits[clde_pkg::POS_SECOND_TENS] + 4'd1;
                            end
                            clde_pkg::POS_SECOND_ONES: begin
                                if (clock_digits[clde_pkg::POS_SECOND_ONES] >= 4'd9) begin
                                    clock_digits[clde_pkg::POS_SECOND_ONES] = 4'd0;
                                    if (clock_digits[clde_pkg::POS_SECOND_TENS] >= 4'd5) begin
                                        clock_digits[clde_pkg::POS_SECOND_TENS] = 4'd0;
                                        advance_minute();
                                    end else begin
                                        clock_digits[clde_pkg::POS_SECOND_TENS] =
                                            clock_digits[clde_pkg::POS_SECOND_TENS] + 4'd1;
                                    end
                                end else begin
                                    clock_digits[clde_pkg::POS_SECOND_ONES] =
                                        clock_digits[clde_pkg::POS_SECOND_ONES] + 4'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    clde_pkg::KEY_DOWN: begin
                        if (clock_digits[cursor_pos] != 4'd0) begin
                            clock_digits[cursor_pos] = clock_digits[cursor_pos] - 4'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end else begin
            pos = scan_pos;
            // in edit mode the cursor digit goes dark during the blink half of the period
            if (!(editing && frame_cnt >= FRAMES_PER_PHASE && pos == cursor_pos)) begin
                rsp.digit_select = ~(8'h01 << pos);
                rsp.segments     = SEG_FONT[clock_digits[pos]];
                if (pos == clde_pkg::POS_HOUR_ONES || pos == clde_pkg::POS_MINUTE_ONES) begin
                    rsp.segments = rsp.segments | clde_pkg::SEG_DP;
                end
            end
            if (pos == clde_pkg::POS_LAST) begin
                scan_pos  = clde_pkg::POS_HOUR_TENS;
                frame_cnt = (frame_cnt == 7'(2 * FRAMES_PER_PHASE - 1)) ? 7'd0
                                                                       : frame_cnt + 7'd1;
            end else begin
                scan_pos = pos + 3'd1;
            end
        end
        rsp.hour_tens       = clock_digits[clde_pkg::POS_HOUR_TENS][1:0];
        rsp.hour_ones       = clock_digits[clde_pkg::POS_HOUR_ONES];
        rsp.minute_tens     = clock_digits[clde_pkg::POS_MINUTE_TENS][2:0];
        rsp.minute_ones     = clock_digits[clde_pkg::POS_MINUTE_ONES];
        rsp.second_tens     = clock_digits[clde_pkg::POS_SECOND_TENS][2:0];
        rsp.second_ones     = clock_digits[clde_pkg::POS_SECOND_ONES];
        rsp.cursor_position = cursor_pos;
        rsp.edit_mode       = editing;
        return rsp;
    endfunction

    function automatic string readout_str(input clde_pkg::t_out_rsp r);
        return $sformatf("sel %h seg %h time %0d%0d:%0d%0d:%0d%0d cursor %0d edit %0d",
                         r.digit_select, r.segments, r.hour_tens, r.hour_ones,
                         r.minute_tens, r.minute_ones, r.second_tens, r.second_ones,
                         r.cursor_position, r.edit_mode);
    endfunction

    task automatic push_key(input logic [7:0] code);
        clde_pkg::t_in_req req;
        req.operation = clde_pkg::OP_KEY;
        req.key_code  = code;
        key_scan_queue.push_back(req);
    endtask

    task automatic push_scan();
        clde_pkg::t_in_req req;
        req.operation = clde_pkg::OP_SCAN;
        req.key_code  = 8'($urandom);
        key_scan_queue.push_back(req);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_readouts.push_back(clock_step(i_in_req));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (key_scan_queue.size() > CALM_TAIL
                             && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 11);
                    i_in_valid <= 1'b0;
                end else if (key_scan_queue.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_req   <= key_scan_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        clde_pkg::t_out_rsp want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_readouts.size() == 0) begin
                    if (errors < 10) begin
                        $display("unexpected response: %s", readout_str(o_out_rsp));
                    end
                    errors = errors + 1;
                end else begin
                    want = expected_readouts.pop_front();
                    if (o_out_rsp !== want) begin
                        if (errors < 10) begin
                            $display("mismatch: expected %s", readout_str(want));
                            $display("          actual   %s", readout_str(o_out_rsp));
                        end
                        errors = errors + 1;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (key_scan_queue.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(0, 11);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("clock_digit_editor_display_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        int n;
        int pick;
        int run;
        clock_digits[clde_pkg::POS_HOUR_TENS]   = 4'(clde_pkg::TIME_RESET.hour_tens);
        clock_digits[clde_pkg::POS_HOUR_ONES]   = clde_pkg::TIME_RESET.hour_ones;
        clock_digits[clde_pkg::POS_MINUTE_TENS] = 4'(clde_pkg::TIME_RESET.minute_tens);
        clock_digits[clde_pkg::POS_MINUTE_ONES] = clde_pkg::TIME_RESET.minute_ones;
        clock_digits[clde_pkg::POS_SECOND_TENS] = 4'(clde_pkg::TIME_RESET.second_tens);
        clock_digits[clde_pkg::POS_SECOND_ONES] = clde_pkg::TIME_RESET.second_ones;
        cursor_pos = clde_pkg::POS_HOUR_TENS;
        editing    = 1'b0;
        frame_cnt  = '0;
        scan_pos   = clde_pkg::POS_HOUR_TENS;

        // keys ignored outside edit mode, then walk the digits from 23:59:50
        push_scan();
        push_key(clde_pkg::KEY_UP);
        push_key(clde_pkg::KEY_RIGHT);
        push_key(clde_pkg::KEY_DOWN);
        push_key(8'h00);
        push_key(clde_pkg::KEY_EDIT);
        push_key(8'hff);
        push_key(clde_pkg::KEY_RIGHT);
        push_key(clde_pkg::KEY_UP);
        push_key(clde_pkg::KEY_DOWN);
        push_key(clde_pkg::KEY_RIGHT);
        push_key(clde_pkg::KEY_DOWN);
        push_key(clde_pkg::KEY_UP);
        push_key(clde_pkg::KEY_RIGHT);
        push_key(clde_pkg::KEY_UP);
        push_key(clde_pkg::KEY_RIGHT);
        push_key(clde_pkg::KEY_UP);
        push_key(clde_pkg::KEY_RIGHT);
        push_key(clde_pkg::KEY_UP);
        push_key(clde_pkg::KEY_RIGHT);
        push_key(clde_pkg::KEY_UP);
        push_scan();
        push_scan();
        push_key(clde_pkg::KEY_EDIT);
        push_scan();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                push_scan();
                n = n + 1;
            end else if (pick < 51) begin
                push_key(clde_pkg::KEY_EDIT);
                n = n + 1;
            end else if (pick < 62) begin
                push_key(clde_pkg::KEY_RIGHT);
                n = n + 1;
            end else if (pick < 80) begin
                // runs of increments push carries through the digits
                run = $urandom_range(1, 14);
                repeat (run) push_key(clde_pkg::KEY_UP);
                n = n + run;
            end else if (pick < 90) begin
                push_key(clde_pkg::KEY_DOWN);
                n = n + 1;
            end else begin
                push_key(8'($urandom));
                n = n + 1;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (key_scan_queue.size() != 0 || i_in_valid || expected_readouts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("clock_digit_editor_display_unit_tb: clean");
        end else begin
            $display("clock_digit_editor_display_unit_tb: errors");
        end
        $finish;
    end

endmodule
